### rtl/core/assert_macros.svh
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### rtl/core/dmsf_pkg.sv
// Types and constants shared by the decimal-mode core.
`timescale 1ns / 1ps
package dmsf_pkg;
  localparam logic [1:0] ST_OUTPUT = 2'd0;
  localparam logic [1:0] ST_HALT   = 2'd1;
  localparam logic [1:0] ST_FAULT  = 2'd2;
  localparam logic [31:0] HALT_WORD = 32'd99;
  localparam logic [16:0] RUN_STEP_LIMIT = 17'd65536;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_IN  = 4'd3;
  localparam logic [3:0] OP_OUT = 4'd4;
  localparam logic [3:0] OP_JT  = 4'd5;
  localparam logic [3:0] OP_JF  = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_EQ  = 4'd8;
endpackage

### rtl/core/decimal_mode_stack_free_cpu_core_top.sv
// Top level of the decimal-mode program-in-memory core.
//
// Input channel (in_valid/in_ready): kind 0 writes load_data at load_address
// and restarts the core; no result beat follows. Kind 1 runs the program with
// input_value until an output, a halt or a fault, and then gives one result
// beat with output_value and run_status on the out channel.
// Config channel (cfg_valid/cfg_ready) writes phase_value while idle.
// Loads can follow back to back. A run goes through, for each instruction,
// the fetch, the digit decode (four divide-by-ten passes through a reciprocal
// multiply), then the operand reads, one extra read per position operand,
// and, for the writing opcodes, the write-back.
// A run on a halted or faulted core goes straight to its result beat.
// Runs are capped at 65536 instructions; a capped run reports a fault.
// One item is in work at a time; in_ready is low while it executes.
// The result sits in an output register; the next item is accepted while it
// waits, but a new run does not finish until the old beat is taken.
// Reset clears the control state; program memory holds no reset value.
module decimal_mode_stack_free_cpu_core_top
  import dmsf_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [9:0]         in_load_address,
  input  logic signed [31:0] in_load_data,
  input  logic signed [31:0] in_input_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_output_value,
  output logic [1:0]         out_run_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_phase_value
);
`include "assert_macros.svh"
  localparam int AW = $clog2(MEM_WORDS);
  localparam int PW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DIVI, S_DECODE, S_RD1, S_RD1I, S_RD2, S_RD2I,
    S_RD3, S_EXEC, S_WRITE, S_DONE
  } state_t;

  state_t      state_r;
  logic [PW-1:0] pc_r;
  logic        phase_pending_r, halted_r, fault_r;
  logic [31:0] last_out_r, input_r;
  logic [3:0]  phase_r;
  logic        out_valid_r;
  logic [31:0] out_val_r;
  logic [1:0]  out_st_r, status_r;
  logic [16:0] steps_r;
  logic [31:0] a_r, b_r, wval_r;
  logic [AW-1:0] dst_r;
  logic [1:0]  k_r;
  logic [3:0]  rem_r;
  logic [31:0] quo_r;
  logic [3:0]  div_pass_r;
  logic [3:0]  op_r;
  logic        m1_r, m2_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  dmsf_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [AW:0] pc_ext;
  logic [2:0]  len;
  logic        len_bad;
  logic [63:0] recip_w;
  logic [31:0] q10_w;
  logic [3:0]  rem_w;
  logic        addr_ok_w;
  logic        a_eq, a_lt;
  logic [31:0] mul_w;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_output_value = out_val_r;
  assign out_run_status = out_st_r;
  assign pc_ext = pc_r;
  assign addr_ok_w = (ram_rdata < 32'(MEM_WORDS));
  // floor(x / 10) = (x * 0xCCCCCCCD) >> 35 for any 32-bit x
  assign recip_w = {32'd0, quo_r} * 64'hCCCC_CCCD;
  assign q10_w = {3'd0, recip_w[63:35]};
  assign rem_w = quo_r[3:0] - ({q10_w[0], 3'b000} + {q10_w[2:0], 1'b0});
  assign mul_w = a_r * b_r;
  assign a_eq = (a_r == b_r);
  assign a_lt = ($signed(a_r) < $signed(b_r));

  always_comb begin
    case (op_r)
      OP_ADD, OP_MUL, OP_LT, OP_EQ: len = 3'd4;
      OP_IN, OP_OUT: len = 3'd2;
      default: len = 3'd3;
    endcase
    len_bad = ((32'(pc_ext) + 32'(len) - 32'd1) >= 32'(MEM_WORDS));
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = wval_r;
    ram_addr = pc_r[AW-1:0] + AW'(k_r);
    unique case (state_r)
      S_IDLE: begin
        ram_we = in_valid && in_kind == KIND_LOAD && 32'(in_load_address) < 32'(MEM_WORDS);
        ram_addr = AW'(in_load_address);
        ram_wdata = in_load_data;
      end
      S_RD1I, S_RD2I: ram_addr = ram_rdata[AW-1:0];
      S_WRITE: begin
        ram_we = 1'b1;
        ram_addr = dst_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= '0;
      phase_pending_r <= 1'b1;
      halted_r <= 1'b0;
      fault_r <= 1'b0;
      last_out_r <= '0;
      phase_r <= '0;
      out_valid_r <= 1'b0;
      k_r <= '0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) phase_r <= cfg_phase_value;
      unique case (state_r)
        S_IDLE: begin
          k_r <= 2'd0;
          if (in_valid) begin
            if (in_kind == KIND_LOAD) begin
              pc_r <= '0;
              phase_pending_r <= 1'b1;
              halted_r <= 1'b0;
              fault_r <= 1'b0;
            end else begin
              input_r <= in_input_value;
              steps_r <= '0;
              if (fault_r) begin
                status_r <= ST_FAULT; state_r <= S_DONE;
              end else if (halted_r) begin
                status_r <= ST_HALT; state_r <= S_DONE;
              end else state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          // ram_rdata is registered: valid in the cycle after its address
          if (steps_r == RUN_STEP_LIMIT) begin
            fault_r <= 1'b1; status_r <= ST_FAULT; state_r <= S_DONE;
          end else if (k_r == 2'd3) begin
            k_r <= 2'd0;
            if (32'(pc_r) >= 32'(MEM_WORDS)) begin
              fault_r <= 1'b1; status_r <= ST_FAULT; state_r <= S_DONE;
            end else if (ram_rdata == HALT_WORD) begin
              halted_r <= 1'b1; status_r <= ST_HALT; state_r <= S_DONE;
            end else if (ram_rdata[31]) begin
              fault_r <= 1'b1; status_r <= ST_FAULT; state_r <= S_DONE;
            end else begin
              quo_r <= ram_rdata;
              div_pass_r <= '0; state_r <= S_DIVI;
            end
          end else k_r <= 2'd3;
        end
        S_DIVI: begin
          rem_r <= rem_w;
          quo_r <= q10_w;
          state_r <= S_DECODE;
        end
        S_DECODE: begin
          // rem_r is the digit just produced, quo_r the value divided by ten
          unique case (div_pass_r)
            4'd0: op_r <= rem_r;
            4'd2: m1_r <= (rem_r != 4'd0);
            4'd3: m2_r <= (rem_r != 4'd0);
            default: ;
          endcase
          if (div_pass_r == 4'd3) begin
            div_pass_r <= '0; state_r <= S_RD1; k_r <= 2'd1;
          end else begin
            div_pass_r <= div_pass_r + 4'd1;
            state_r <= S_DIVI;
          end
        end
        S_RD1: begin
          if (op_r == 4'd0 || op_r == 4'd9 || op_r > OP_EQ || len_bad) begin
            fault_r <= 1'b1; status_r <= ST_FAULT; state_r <= S_DONE;
          end else state_r <= S_RD1I;
        end
        S_RD1I: begin
          // ram_rdata = word at pc+1
          if (op_r == OP_IN) begin
            if (!addr_ok_w) begin
              fault_r <= 1'b1; status_r <= ST_FAULT; state_r <= S_DONE;
            end else begin
              dst_r <= ram_rdata[AW-1:0];
              wval_r <= phase_pending_r ? {28'd0, phase_r} : input_r;
              phase_pending_r <= 1'b0;
              pc_r <= pc_r + PW'(2);
              state_r <= S_WRITE;
            end
          end else if (m1_r) begin
            a_r <= ram_rdata; k_r <= 2'd2; state_r <= S_RD2;
          end else if (!addr_ok_w) begin
            fault_r <= 1'b1; status_r <= ST_FAULT; state_r <= S_DONE;
          end else begin
            k_r <= 2'd1; op_r <= op_r; state_r <= S_EXEC; div_pass_r <= 4'd1;
          end
        end
        S_EXEC: begin
          // indirect read data landed; div_pass_r marks which operand
          if (div_pass_r == 4'd1) begin
            a_r <= ram_rdata; k_r <= 2'd2; div_pass_r <= '0; state_r <= S_RD2;
          end else if (div_pass_r == 4'd2) begin
            b_r <= ram_rdata; div_pass_r <= '0; k_r <= 2'd3; state_r <= S_RD3;
          end else begin
            unique case (op_r)
              OP_ADD: wval_r <= a_r + b_r;
              OP_MUL: wval_r <= mul_w;
              OP_LT: wval_r <= {31'd0, a_lt};
              default: wval_r <= {31'd0, a_eq};
            endcase
            pc_r <= pc_r + PW'(4);
            state_r <= S_WRITE;
          end
        end
        S_RD2: begin
          if (op_r == OP_OUT) begin
            last_out_r <= a_r; pc_r <= pc_r + PW'(2);
            status_r <= ST_OUTPUT; state_r <= S_DONE;
          end else state_r <= S_RD2I;
        end
        S_RD2I: begin
          if (m2_r) begin
            b_r <= ram_rdata; k_r <= 2'd3; state_r <= S_RD3;
          end else if (!addr_ok_w) begin
            fault_r <= 1'b1; status_r <= ST_FAULT; state_r <= S_DONE;
          end else begin
            div_pass_r <= 4'd2; state_r <= S_EXEC;
          end
        end
        S_RD3: begin
          if (op_r == OP_JT || op_r == OP_JF) begin
            if ((op_r == OP_JT) == (a_r != 32'd0)) begin
              if (b_r >= 32'(MEM_WORDS)) begin
                fault_r <= 1'b1; status_r <= ST_FAULT; state_r <= S_DONE;
              end else begin
                pc_r <= b_r[PW-1:0]; k_r <= 2'd0;
                steps_r <= steps_r + 17'd1; state_r <= S_FETCH;
              end
            end else begin
              pc_r <= pc_r + PW'(3); k_r <= 2'd0;
              steps_r <= steps_r + 17'd1; state_r <= S_FETCH;
            end
          end else if (div_pass_r == 4'd0) begin
            div_pass_r <= 4'd4;
          end else begin
            div_pass_r <= '0;
            if (!addr_ok_w) begin
              fault_r <= 1'b1; status_r <= ST_FAULT; state_r <= S_DONE;
            end else begin
              dst_r <= ram_rdata[AW-1:0]; state_r <= S_EXEC;
            end
          end
        end
        S_WRITE: begin
          k_r <= 2'd0; steps_r <= steps_r + 17'd1; state_r <= S_FETCH;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_val_r <= last_out_r;
            out_st_r <= status_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_hold, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_output_value)),
    "result beat changed while stalled")
  `ASSERT_NEVER(a_busy_ready, clk, rst_n,
    (in_ready && state_r != S_IDLE), "ready while busy")
  `ASSERT_NEVER(a_status_code, clk, rst_n,
    (out_valid && out_run_status == 2'd3), "bad status code")
endmodule

### rtl/core/dmsf_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module dmsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### dv/dmsf_checker.sv
// Checker for the decimal-mode core: predicts each run result and compares the out beats.
`timescale 1ns / 1ps
module dmsf_checker
  import dmsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_kind,
  input  logic [9:0]         in_load_address,
  input  logic signed [31:0] in_load_data,
  input  logic signed [31:0] in_input_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_output_value,
  input  logic [1:0]         out_run_status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [3:0]         cfg_phase_value,
  output int                 errors,
  output int                 pending,
  output int                 beats_checked
);
  localparam int unsigned MEMW = 1024;
  localparam logic [1:0] ST_CONT = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } run_result_t;

  run_result_t result_q[$];
  logic [31:0] pmem [MEMW];
  int unsigned core_pc;
  logic        phase_due;
  logic        halted;
  logic        faulted;
  logic [31:0] last_out;
  logic [3:0]  phase_reg;

  assign pending = result_q.size();

  function automatic logic [1:0] exec_instr(input logic [31:0] inval);
    int unsigned p, len, op, m1, m2;
    logic [31:0] cmd, a, b, w, dst;
    p = core_pc;
    if (p >= MEMW) return ST_FAULT;
    cmd = pmem[p];
    if (cmd == HALT_WORD) return ST_HALT;
    if (cmd[31]) return ST_FAULT;
    op = cmd % 10;
    m1 = (cmd / 100) % 10;
    m2 = (cmd / 1000) % 10;
    case (op)
      OP_ADD, OP_MUL, OP_LT, OP_EQ: len = 4;
      OP_IN, OP_OUT: len = 2;
      OP_JT, OP_JF: len = 3;
      default: return ST_FAULT;
    endcase
    if (p + len - 1 >= MEMW) return ST_FAULT;
    if (op == OP_IN) begin
      dst = pmem[p+1];
      if (dst >= MEMW) return ST_FAULT;
      if (phase_due) begin
        pmem[dst[9:0]] = {28'd0, phase_reg};
        phase_due = 1'b0;
      end else begin
        pmem[dst[9:0]] = inval;
      end
      core_pc = p + 2;
      return ST_CONT;
    end
    w = pmem[p+1];
    if (m1 != 0) a = w;
    else if (w >= MEMW) return ST_FAULT;
    else a = pmem[w[9:0]];
    if (op == OP_OUT) begin
      last_out = a;
      core_pc = p + 2;
      return ST_OUTPUT;
    end
    w = pmem[p+2];
    if (m2 != 0) b = w;
    else if (w >= MEMW) return ST_FAULT;
    else b = pmem[w[9:0]];
    if (op == OP_JT || op == OP_JF) begin
      if ((op == OP_JT) ? (a != 0) : (a == 0)) begin
        if (b >= MEMW) return ST_FAULT;
        core_pc = b;
      end else begin
        core_pc = p + 3;
      end
      return ST_CONT;
    end
    dst = pmem[p+3];
    if (dst >= MEMW) return ST_FAULT;
    case (op)
      OP_ADD: pmem[dst[9:0]] = a + b;
      OP_MUL: pmem[dst[9:0]] = a * b;
      OP_LT: pmem[dst[9:0]] = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      default: pmem[dst[9:0]] = (a == b) ? 32'd1 : 32'd0;
    endcase
    core_pc = p + 4;
    return ST_CONT;
  endfunction

  function automatic run_result_t predict_run(input logic [31:0] inval);
    run_result_t r;
    logic [1:0] st;
    if (faulted) begin
      st = ST_FAULT;
    end else if (halted) begin
      st = ST_HALT;
    end else begin
      st = ST_CONT;
      for (int unsigned n = 0; n < RUN_STEP_LIMIT; n++) begin
        st = exec_instr(inval);
        if (st != ST_CONT) break;
      end
      if (st == ST_CONT) st = ST_FAULT;
      if (st == ST_HALT) halted = 1'b1;
      if (st == ST_FAULT) faulted = 1'b1;
    end
    r.value = last_out;
    r.status = st;
    return r;
  endfunction

  always @(posedge clk) begin
    run_result_t exp_r;
    if (!rst_n) begin
      errors = 0;
      beats_checked = 0;
      core_pc = 0;
      phase_due = 1'b1;
      halted = 1'b0;
      faulted = 1'b0;
      last_out = '0;
      phase_reg = '0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        beats_checked++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected out beat value %h status %0d", $time,
                   out_output_value, out_run_status);
        end else begin
          exp_r = result_q.pop_front();
          if (out_output_value !== exp_r.value) begin
            errors++;
            $display("%0t: output_value expected %h actual %h", $time, exp_r.value,
                     out_output_value);
          end
          if (out_run_status !== exp_r.status) begin
            errors++;
            $display("%0t: run_status expected %0d actual %0d", $time, exp_r.status,
                     out_run_status);
          end
        end
      end
      if (cfg_valid && cfg_ready) phase_reg = cfg_phase_value;
      if (in_valid && in_ready) begin
        if (in_kind == KIND_LOAD) begin
          pmem[in_load_address] = in_load_data;
          core_pc = 0;
          phase_due = 1'b1;
          halted = 1'b0;
          faulted = 1'b0;
        end else begin
          exp_r = predict_run(in_input_value);
          result_q = {result_q, exp_r};
        end
      end
    end
  end
endmodule

### dv/tb_decimal_mode_stack_free_cpu_core_top.sv
// Testbench top for the decimal-mode core: stimulus, reset and the verdict.
`timescale 1ns / 1ps
module tb_decimal_mode_stack_free_cpu_core_top;
  import dmsf_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = 1'b0;
  logic [9:0]         in_load_address = '0;
  logic signed [31:0] in_load_data = '0;
  logic signed [31:0] in_input_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_output_value;
  logic [1:0]         out_run_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_phase_value = '0;

  int errors, pending, beats_checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int programs_run = 0;
  longint cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  decimal_mode_stack_free_cpu_core_top i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_load_address, .in_load_data,
    .in_input_value, .out_valid, .out_ready, .out_output_value, .out_run_status,
    .cfg_valid, .cfg_ready, .cfg_phase_value
  );

  dmsf_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_load_address, .in_load_data,
    .in_input_value, .out_valid, .out_ready, .out_output_value, .out_run_status,
    .cfg_valid, .cfg_ready, .cfg_phase_value, .errors, .pending, .beats_checked
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_decimal_mode_stack_free_cpu_core_top failed");
      $finish;
    end
  end

  task automatic send_beat(input logic kind, input logic [9:0] addr,
                           input logic [31:0] data, input logic [31:0] inval);
    logic r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_load_address <= addr;
    in_load_data <= data;
    in_input_value <= inval;
    do begin
      @(negedge clk);
      r = in_ready;
      @(posedge clk);
    end while (!r);
    items_sent++;
  endtask

  task automatic load_word(input logic [9:0] addr, input logic [31:0] data);
    send_beat(KIND_LOAD, addr, data, $urandom);
  endtask

  task automatic run_core(input logic [31:0] inval);
    send_beat(KIND_RUN, 10'($urandom), $urandom, inval);
  endtask

  task automatic load_program(input logic [31:0] words[$]);
    foreach (words[i]) load_word(i[9:0], words[i]);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_phase(input logic [3:0] v);
    logic r;
    cfg_valid <= 1'b1;
    cfg_phase_value <= v;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
    cfg_valid <= 1'b0;
  endtask

  // program with forward jumps only, data kept in words 100..115; some carry a flawed instruction
  task automatic random_program;
    logic [31:0] words[$];
    int ops[$];
    int starts[$];
    int n, addr, nout, op, m1, m2, j, flaw;
    logic [31:0] cmd, opnd;
    n = $urandom_range(3, 8);
    addr = 0;
    nout = 0;
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(1, 8);
      ops = {ops, op};
      starts = {starts, addr};
      addr += (op == 3 || op == 4) ? 2 : ((op == 5 || op == 6) ? 3 : 4);
      if (op == 4) nout++;
    end
    starts = {starts, addr};
    flaw = ($urandom_range(99) < 12) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      op = ops[i];
      m1 = ($urandom_range(1)) ? $urandom_range(1, 9) : 0;
      m2 = (op == 5 || op == 6) ? $urandom_range(1, 9)
                                : (($urandom_range(1)) ? $urandom_range(1, 9) : 0);
      cmd = op + 10 * $urandom_range(9) + 100 * m1 + 1000 * m2 + 10000 * $urandom_range(30);
      if (i == flaw && $urandom_range(2) == 0)
        cmd = ($urandom_range(1)) ? ($urandom | 32'h8000_0000) : 32'd10 * $urandom_range(99);
      words = {words, cmd};
      for (int k = 1; k < ((op == 3 || op == 4) ? 2 : ((op == 5 || op == 6) ? 3 : 4)); k++) begin
        if (op == 3 || k == 3) opnd = $urandom_range(100, 115);
        else if ((k == 1 ? m1 : m2) == 0) opnd = $urandom_range(100, 115);
        else opnd = $urandom;
        if ((op == 5 || op == 6) && k == 2) begin
          j = $urandom_range(i + 1, n);
          opnd = starts[j];
        end
        if (i == flaw && k == 1) opnd = $urandom | 32'h0000_0400;
        words = {words, opnd};
      end
    end
    words = {words, HALT_WORD};
    load_program(words);
    repeat (nout + $urandom_range(1, 2)) run_core($urandom);
    if ($urandom_range(9) == 0) drain;
    programs_run++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_phase(4'd0);
    for (int a = 100; a < 116; a++) load_word(a[9:0], HALT_WORD);
    drain;
    write_phase(4'd6);

    // phase value feeds the first input only
    load_program('{3, 100, 3, 101, 1, 100, 101, 102, 4, 102, 4, 101, 99});
    run_core(32'h7fff_ffff);
    run_core(32'h8000_0000);
    run_core(32'hffff_ffff);
    run_core('0);
    load_program('{1102, 32'h8000_0000, 32'hffff_ffff, 100, 4, 100,
                   1107, 32'hffff_ffff, 1, 101, 4, 101, 1108, 5, 5, 102, 4, 102, 99});
    repeat (4) run_core($urandom);
    load_program('{1105, 0, 9, 1106, 0, 7, 99, 104, 55, 99});
    repeat (2) run_core($urandom);
    load_program('{32'hffff_fffb});
    repeat (2) run_core($urandom);
    load_program('{10});
    run_core($urandom);
    load_program('{199});
    run_core($urandom);
    load_program('{1, 2000, 0, 100});
    run_core($urandom);
    load_program('{1105, 1, 5000});
    run_core($urandom);
    load_program('{1101, 1, 1, 4096});
    run_core($urandom);
    load_program('{3, 32'hffff_ffff});
    run_core($urandom);
    load_word(10'd1021, 1101);
    load_program('{1105, 1, 1021});
    run_core($urandom);
    // endless loop runs into the step cap
    load_program('{1105, 1, 0});
    run_core($urandom);
    drain;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 38 : ((ph == 1) ? 76 : 0);
      recv_idle_pct = (ph == 0) ? 76 : ((ph == 1) ? 38 : 0);
      write_phase((ph == 0) ? 4'd9 : ((ph == 1) ? 4'($urandom_range(9)) : 4'd0));
      for (int base = items_sent; items_sent < base + 100;) random_program;
      drain;
    end

    $display("%0d items sent over %0d random programs, %0d result beats checked",
             items_sent, programs_run, beats_checked);
    $display("covered all opcodes, both modes, halt, fault cases and the step cap");
    if (errors == 0 && pending == 0) begin
      $display("tb_decimal_mode_stack_free_cpu_core_top passed");
    end else begin
      $display("tb_decimal_mode_stack_free_cpu_core_top failed");
    end
    $finish;
  end
endmodule
